// ===== rtl/core/swsp_pkg.sv =====
// Shared types and constants for the shell word splitter.
`default_nettype none

package swsp_pkg;

    // Argument count limit and the saturation point of the 8-bit counter.
    localparam int MAX_ARG_COUNT = 255;
    localparam logic [7:0] ARG_CAP = (MAX_ARG_COUNT > 255) ? 8'd255 : 8'(MAX_ARG_COUNT);

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BKSP   = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } t_swsp_res;

    // One queued request: one or two results for one input byte.
    typedef struct packed {
        logic      two;
        t_swsp_res r0;
        t_swsp_res r1;
    } t_swsp_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/swsp_front.sv =====
// Front end: accepts input bytes, runs the scanner and builds result requests.
`default_nettype none

module swsp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic               i_full,
    output logic                    o_stall,
    output logic                    o_push,
    output swsp_pkg::t_swsp_cmd     o_cmd
);
    import swsp_pkg::*;

    // Scanner modes.
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_ARG     = 3'd1;
    localparam logic [2:0] MODE_ARG_ESC = 3'd2;
    localparam logic [2:0] MODE_SQ      = 3'd3;
    localparam logic [2:0] MODE_SQ_ESC  = 3'd4;
    localparam logic [2:0] MODE_DQ      = 3'd5;
    localparam logic [2:0] MODE_DQ_ESC  = 3'd6;

    logic [2:0] r_mode, n_mode;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] c;
    logic       accept;
    logic       is_skip;
    logic [7:0] cnt_eff;
    logic [7:0] idx;
    logic       do_arg;
    logic       has_res;
    t_swsp_cmd  cmd;

    // Converts the escapes that double quotes recognize.
    function automatic logic [7:0] cook(input logic [7:0] ch);
        logic [7:0] r;
        begin
            case (ch)
                8'h61:   r = 8'h07;
                8'h62:   r = 8'h08;
                8'h74:   r = 8'h09;
                8'h6E:   r = 8'h0A;
                8'h76:   r = 8'h0B;
                8'h66:   r = 8'h0C;
                8'h72:   r = 8'h0D;
                default: r = ch;
            endcase
            return r;
        end
    endfunction

    assign c       = i_in_byte;
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_skip = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    // A new argument starts on a non-skip byte between arguments.
    always_comb begin
        cnt_eff = r_cnt;
        if (r_mode == MODE_BETWEEN && c != CH_NUL && !is_skip && r_cnt < ARG_CAP) begin
            cnt_eff = r_cnt + 8'd1;
        end
    end

    assign idx = (cnt_eff == 8'd0) ? 8'd0 : cnt_eff - 8'd1;

    // Classification of the byte against the current mode.
    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        do_arg  = 1'b0;
        has_res = 1'b0;
        cmd     = '0;
        cmd.r0.index = idx;
        cmd.r1.index = idx;
        unique case (r_mode)
            MODE_BETWEEN: begin
                if (c == CH_NUL) begin
                    has_res       = 1'b1;
                    cmd.r0.kind   = KIND_DONE;
                    cmd.r0.index  = r_cnt;
                    n_cnt         = 8'd0;
                end else if (!is_skip) begin
                    n_cnt  = cnt_eff;
                    n_mode = MODE_ARG;
                    do_arg = 1'b1;
                end
            end
            MODE_ARG: begin
                do_arg = 1'b1;
            end
            MODE_ARG_ESC: begin
                has_res = 1'b1;
                if (c == CH_NUL) begin
                    cmd.two      = 1'b1;
                    cmd.r0.kind  = KIND_END;
                    cmd.r1.kind  = KIND_DONE;
                    cmd.r1.index = cnt_eff;
                    n_mode       = MODE_BETWEEN;
                    n_cnt        = 8'd0;
                end else begin
                    cmd.r0.kind = KIND_BYTE;
                    cmd.r0.data = c;
                    n_mode      = MODE_ARG;
                end
            end
            MODE_SQ, MODE_DQ: begin
                if (c == CH_NUL) begin
                    has_res      = 1'b1;
                    cmd.r0.kind  = KIND_ERR;
                    cmd.r0.index = cnt_eff;
                    n_mode       = MODE_BETWEEN;
                    n_cnt        = 8'd0;
                end else if (c == ((r_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE)) begin
                    n_mode = MODE_ARG;
                end else if (c == CH_BSLASH) begin
                    n_mode = (r_mode == MODE_SQ) ? MODE_SQ_ESC : MODE_DQ_ESC;
                end else begin
                    has_res     = 1'b1;
                    cmd.r0.kind = KIND_BYTE;
                    cmd.r0.data = c;
                end
            end
            MODE_SQ_ESC: begin
                has_res = 1'b1;
                if (c == CH_NUL) begin
                    cmd.r0.kind  = KIND_ERR;
                    cmd.r0.index = cnt_eff;
                    n_mode       = MODE_BETWEEN;
                    n_cnt        = 8'd0;
                end else begin
                    n_mode = MODE_SQ;
                    if (c != CH_BSLASH && c != CH_SQUOTE) begin
                        // Unknown escape keeps its backslash.
                        cmd.two     = 1'b1;
                        cmd.r0.kind = KIND_BYTE;
                        cmd.r0.data = CH_BSLASH;
                        cmd.r1.kind = KIND_BYTE;
                        cmd.r1.data = c;
                    end else begin
                        cmd.r0.kind = KIND_BYTE;
                        cmd.r0.data = c;
                    end
                end
            end
            MODE_DQ_ESC: begin
                has_res = 1'b1;
                if (c == CH_NUL) begin
                    cmd.r0.kind  = KIND_ERR;
                    cmd.r0.index = cnt_eff;
                    n_mode       = MODE_BETWEEN;
                    n_cnt        = 8'd0;
                end else begin
                    cmd.r0.kind = KIND_BYTE;
                    cmd.r0.data = cook(c);
                    n_mode      = MODE_DQ;
                end
            end
            default: begin
                n_mode = MODE_BETWEEN;
            end
        endcase

        // Handling of a byte inside an unquoted argument.
        if (do_arg) begin
            if (c == CH_NUL) begin
                has_res      = 1'b1;
                cmd.two      = 1'b1;
                cmd.r0.kind  = KIND_END;
                cmd.r1.kind  = KIND_DONE;
                cmd.r1.index = cnt_eff;
                n_mode       = MODE_BETWEEN;
                n_cnt        = 8'd0;
            end else if (c == CH_BSLASH) begin
                n_mode = MODE_ARG_ESC;
            end else if (c == CH_SQUOTE) begin
                n_mode = MODE_SQ;
            end else if (c == CH_DQUOTE) begin
                n_mode = MODE_DQ;
            end else if (is_skip || c == CH_BKSP) begin
                has_res     = 1'b1;
                cmd.r0.kind = KIND_END;
                n_mode      = MODE_BETWEEN;
            end else begin
                has_res     = 1'b1;
                cmd.r0.kind = KIND_BYTE;
                cmd.r0.data = c;
            end
        end
    end

    assign o_push = accept && has_res;
    assign o_cmd  = cmd;

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_cnt  <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/swsp_queue.sv =====
// Short request queue between the front end and the back end.
`default_nettype none

module swsp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire swsp_pkg::t_swsp_cmd i_cmd,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output swsp_pkg::t_swsp_cmd     o_cmd
);
    import swsp_pkg::*;

    localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CntW = $clog2(Q_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Q_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Q_DEPTH);

    t_swsp_cmd       r_mem [Q_DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CntFull);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrLast) ? '0 : r_wr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrLast) ? '0 : r_rd + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/swsp_back.sv =====
// Back end: expands queued requests into result items on the output register.
`default_nettype none

module swsp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire swsp_pkg::t_swsp_cmd i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_out_byte,
    output logic [7:0]              o_arg_index,
    output logic                    o_last
);
    import swsp_pkg::*;

    logic      r_valid;
    logic      r_second;
    t_swsp_res r_res;
    logic      r_last;
    logic      load;

    // The output register takes a new result when empty or being drained.
    assign load    = i_q_valid && (!r_valid || !i_stall);
    assign o_q_pop = load && (r_second || !i_q_cmd.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= !r_second && i_q_cmd.two;
        end else if (!i_stall) begin
            r_valid  <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= r_second ? i_q_cmd.r1 : i_q_cmd.r0;
            r_last <= r_second || !i_q_cmd.two;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_res.kind;
    assign o_out_byte  = r_res.data;
    assign o_arg_index = r_res.index;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/shell_word_splitter.sv =====
// Shell-style argument splitter: front end, request queue and back end.
// Throughput: one byte per cycle while not stalled; a byte's two results leave in turn.
// Path: an accepted byte's request is written into the queue, and its first result
// then moves to the output register, directly if the queue was empty and i_stall is low.
// The four-entry request queue absorbs output stalls; the input stalls only when it is full.
// Reset (synchronous, active low) clears the scanner, the queue and the output register.
`default_nettype none

module shell_word_splitter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic [7:0]      o_arg_index,
    output logic            o_last
);
    import swsp_pkg::*;

    logic      full;
    logic      push;
    t_swsp_cmd push_cmd;
    logic      q_valid;
    t_swsp_cmd q_cmd;
    logic      q_pop;

    // Scanner.
    swsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // Decoupling queue.
    swsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Result emitter.
    swsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_arg_index (o_arg_index),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
